@@ hdl/slli_pkg.sv @@
// Shared types and constants for the sequential list unit.
// Used by the cell, locate and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package slli_pkg;

    // Field widths of the stream words.
    localparam int TYPE_W = 2;
    localparam int SLOT_W = 5;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;

    // Match flags are grouped in eights for the locate tree.
    localparam int GRP   = 8;
    localparam int GRP_W = 3;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_LOCATE = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOPOS = 2'd2;

    // Per-cell control for one cycle.
    typedef struct packed {
        logic load;        // take the new byte
        logic take_lower;  // take the entry of the cell below
        logic take_upper;  // take the entry of the cell above
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ hdl/slli_cell.sv @@
// One list cell: holds a single entry and trades it with its neighbors.
// Depends on slli_pkg for the control struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module slli_cell (
    input  wire logic                       i_clk,
    input  wire slli_pkg::t_cell_ctrl       i_ctrl,
    input  wire logic [slli_pkg::BYTE_W-1:0] i_load_byte,
    input  wire logic [slli_pkg::BYTE_W-1:0] i_from_lower,
    input  wire logic [slli_pkg::BYTE_W-1:0] i_from_upper,
    input  wire logic [slli_pkg::BYTE_W-1:0] i_key,
    output logic [slli_pkg::BYTE_W-1:0]      o_data,
    output logic                             o_match
);
    import slli_pkg::*;

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] n_data;

    // Pick the next entry: new byte, neighbor below, neighbor above, or hold.
    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_load_byte;
        end else if (i_ctrl.take_lower) begin
            n_data = i_from_lower;
        end else if (i_ctrl.take_upper) begin
            n_data = i_from_upper;
        end
    end

    // The entry itself has no reset; positions past the length are never read.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

`default_nettype wire

@@ hdl/slli_locate.sv @@
// Registered priority search over the cell match flags.
// Depends on slli_pkg; finds the first matching position in three register stages.
`timescale 1ns / 1ps
`default_nettype none

module slli_locate #(
    parameter int CAPACITY = 16,
    parameter int CW       = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [CAPACITY-1:0]         i_match,
    input  wire logic [CW-1:0]               i_count,
    output logic                             o_done,
    output logic [slli_pkg::SLOT_W-1:0]      o_found
);
    import slli_pkg::*;

    localparam int NG  = (CAPACITY + GRP - 1) / GRP;
    localparam int VW  = NG * GRP;
    localparam int FW  = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

    // Stage one: captured flags and length.
    logic [VW-1:0]    r_vec;
    logic [CW-1:0]    r_cnt0;
    logic             r_v0;

    // Stage two: per-group hit and first index inside the group.
    logic [NG-1:0]    r_gany;
    logic [GRP_W-1:0] r_gidx [NG];
    logic [CW-1:0]    r_cnt1;
    logic             r_v1;

    logic [NG-1:0]    n_gany;
    logic [GRP_W-1:0] n_gidx [NG];
    logic [FW-1:0]    n_found;

    logic             r_done;
    logic [SLOT_W-1:0] r_found;

    // Valid flags of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v0   <= i_start;
            r_v1   <= r_v0;
            r_done <= r_v1;
        end
    end

    // Capture the flags, padded with zeros up to whole groups.
    always_ff @(posedge i_clk) begin
        r_vec  <= VW'(i_match);
        r_cnt0 <= i_count;
    end

    // First hit inside each group of eight, lowest position wins.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_gany[g] = |r_vec[g*GRP +: GRP];
            n_gidx[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (r_vec[g*GRP + j]) begin
                    n_gidx[g] = GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gany <= n_gany;
        r_gidx <= n_gidx;
        r_cnt1 <= r_cnt0;
    end

    // Pick the lowest group with a hit; with no hit the answer is length plus one.
    always_comb begin
        n_found = FW'(r_cnt1) + FW'(1);
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_gany[g]) begin
                n_found = FW'(g * GRP) + FW'(r_gidx[g]) + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found[SLOT_W-1:0];
    end

    assign o_done  = r_done;
    assign o_found = r_found;

endmodule

`default_nettype wire

@@ hdl/sequential_list_insert_delete_locate_unit.sv @@
// Top level of the sequential list unit: request decode, cell chain, output word.
// Depends on slli_pkg, slli_cell and slli_locate.
`timescale 1ns / 1ps
`default_nettype none

// An ordered list of up to CAPACITY bytes held in a chain of cells, one entry
// per cell. Each input word carries one request: insert a byte at a one-based
// position (1 to length+1), delete the entry at a position (1 to length), or
// locate the first position that holds a byte (length+1 when absent). Every
// request returns exactly one output word with a status (ok, list full, or no
// such position), the located position (zero except for locate) and the
// length after the request; a refused request leaves the list unchanged.
// Insert and delete shift all cells in parallel, so a new word is taken every
// cycle while the output side keeps up and no locate is in progress. Locate
// sends the match flags of all cells through a two-level registered priority
// tree before the result is written to the output register. No clearing pass
// is needed after reset; the list starts empty.
module sequential_list_insert_delete_locate_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [4:0] slot, [12:5] item_byte, [15:13] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [4:0] found_slot, [9:5] length, [15:10] zero
    output logic [1:0]       m_tuser    // [1:0] status
);
    import slli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOCATE = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [SLOT_W-1:0] r_found;
    logic [SLOT_W-1:0] r_length;

    logic [TYPE_W-1:0] w_req;
    logic [SLOT_W-1:0] w_slot;
    logic [BYTE_W-1:0] w_byte;
    logic              w_fire;
    logic [PW-1:0]     w_pos;
    logic [PW-1:0]     w_cnt;
    logic [PW-1:0]     w_idx;
    logic              w_full;
    logic              w_ins_ok;
    logic              w_del_ok;
    logic              w_do_ins;
    logic              w_do_del;
    logic              w_start;
    logic [STAT_W-1:0] w_status;

    logic [BYTE_W-1:0] w_data  [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_hit;
    logic              w_loc_done;
    logic [SLOT_W-1:0] w_loc_found;

    // Unpack the request word.
    assign w_req  = s_tuser[TYPE_W-1:0];
    assign w_slot = s_tdata[SLOT_W-1:0];
    assign w_byte = s_tdata[SLOT_W +: BYTE_W];

    // Take a word when idle and the output register is free or being emptied.
    assign s_tready = (r_state == S_IDLE) && (!r_out_valid || m_tready);
    assign w_fire   = s_tvalid && s_tready;

    // Position checks against the current length.
    assign w_pos    = PW'(w_slot);
    assign w_cnt    = PW'(r_count);
    assign w_idx    = w_pos - PW'(1);
    assign w_full   = (w_cnt >= PW'(CAPACITY));
    assign w_ins_ok = !w_full && (w_pos != '0) && (w_pos <= w_cnt + PW'(1));
    assign w_del_ok = (w_pos != '0) && (w_pos <= w_cnt);
    assign w_do_ins = w_fire && (w_req == REQ_INSERT) && w_ins_ok;
    assign w_do_del = w_fire && (w_req == REQ_DELETE) && w_del_ok;
    assign w_start  = w_fire && (w_req == REQ_LOCATE);

    // Status of a request that completes at once.
    always_comb begin
        w_status = ST_OK;
        case (w_req)
            REQ_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (!w_ins_ok) begin
                    w_status = ST_NOPOS;
                end
            end
            REQ_DELETE: begin
                if (!w_del_ok) begin
                    w_status = ST_NOPOS;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // The chain of cells; each cell shifts toward its neighbor as told.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctrl        w_ctrl;
        logic [BYTE_W-1:0] w_lower;
        logic [BYTE_W-1:0] w_upper;

        assign w_ctrl.load       = w_do_ins && (w_idx == PW'(i));
        assign w_ctrl.take_lower = w_do_ins && (PW'(i) > w_idx);
        assign w_ctrl.take_upper = w_do_del && (PW'(i) >= w_idx);

        if (i == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_inner_lo
            assign w_lower = w_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_inner_hi
            assign w_upper = w_data[i+1];
        end

        slli_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_byte (w_byte),
            .i_from_lower(w_lower),
            .i_from_upper(w_upper),
            .i_key       (w_byte),
            .o_data      (w_data[i]),
            .o_match     (w_match[i])
        );

        // Only positions inside the list count as hits.
        assign w_hit[i] = w_match[i] && (PW'(i) < w_cnt);
    end

    // Priority search for locate.
    slli_locate #(
        .CAPACITY(CAPACITY),
        .CW      (CW)
    ) u_locate (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_match(w_hit),
        .i_count(r_count),
        .o_done (w_loc_done),
        .o_found(w_loc_found)
    );

    // Length update and sequencing.
    always_comb begin
        n_count = r_count;
        n_state = r_state;
        if (w_do_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_do_del) begin
            n_count = r_count - CW'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_LOCATE;
                end
            end
            S_LOCATE: begin
                if (w_loc_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Output register: a new word is loaded over one that is being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_fire && !w_start) || w_loc_done) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_loc_done) begin
            r_status <= ST_OK;
            r_found  <= w_loc_found;
            r_length <= SLOT_W'(r_count);
        end else if (w_fire && !w_start) begin
            r_status <= w_status;
            r_found  <= '0;
            r_length <= SLOT_W'(n_count);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_length, r_found};
    assign m_tuser  = r_status;

endmodule

`default_nettype wire

@@ test/sequential_list_insert_delete_locate_unit_tb.sv @@
// Self-checking testbench for the sequential list unit: directed and random requests.
// Predicts every output word from its own copy of the list; depends on slli_pkg and the unit.
`timescale 1ns / 1ps

module sequential_list_insert_delete_locate_unit_tb;

    import slli_pkg::*;

    localparam int CAP          = 16;
    localparam int RANDOM_REQS  = 1450;
    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_WAIT  = 20;
    localparam int REPORT_LIMIT = 10;

    // The fourth request code is unnamed in the package; the unit only answers it with ok.
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] item_byte;
        logic              drain_first;  // hold this word back until all results are in
    } t_list_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] found_slot;
        logic [SLOT_W-1:0] length;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [4:0] slot, [12:5] item_byte, [15:13] zero
    logic [1:0]  s_tuser = '0;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [4:0] found_slot, [9:5] length, [15:10] zero
    logic [1:0]  m_tuser;        // [1:0] status

    // Words waiting to be sent and results waiting to arrive.
    t_list_req    pending_reqs[$];
    t_list_result expected_results[$];

    // Predicted list contents.
    logic [BYTE_W-1:0] list_bytes[0:CAP-1];
    int                list_len = 0;

    // Length as seen by the stimulus generator, used to pick legal positions.
    int gen_len = 0;

    t_list_req   cur_req = '0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    int          reqs_accepted = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    sequential_list_insert_delete_locate_unit #(
        .CAPACITY (CAP)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one accepted request to the predicted list and queue its result.
    function automatic void apply_request(input t_list_req r);
        t_list_result res;
        int           pos;
        pos = r.slot;
        res.status     = ST_OK;
        res.found_slot = '0;
        if (r.req_type == REQ_INSERT) begin
            if (list_len >= CAP) begin
                res.status = ST_FULL;
            end else if (pos < 1 || pos > list_len + 1) begin
                res.status = ST_NOPOS;
            end else begin
                for (int i = list_len; i >= pos; i--) list_bytes[i] = list_bytes[i-1];
                list_bytes[pos-1] = r.item_byte;
                list_len++;
            end
        end else if (r.req_type == REQ_DELETE) begin
            if (pos < 1 || pos > list_len) begin
                res.status = ST_NOPOS;
            end else begin
                for (int i = pos; i < list_len; i++) list_bytes[i-1] = list_bytes[i];
                list_len--;
            end
        end else if (r.req_type == REQ_LOCATE) begin
            // Scan downward so the lowest matching position wins.
            res.found_slot = SLOT_W'(list_len + 1);
            for (int i = list_len - 1; i >= 0; i--) begin
                if (list_bytes[i] == r.item_byte) res.found_slot = SLOT_W'(i + 1);
            end
        end
        res.length = SLOT_W'(list_len);
        expected_results.push_back(res);
    endfunction

    // Queue one request word and track the length it leaves behind.
    task automatic add_req(input logic [TYPE_W-1:0] kind, input int slot, input int value,
                           input logic drain);
        t_list_req r;
        r.req_type    = kind;
        r.slot        = slot[SLOT_W-1:0];
        r.item_byte   = value[BYTE_W-1:0];
        r.drain_first = drain;
        pending_reqs.push_back(r);
        if (kind == REQ_INSERT && gen_len < CAP && slot >= 1 && slot <= gen_len + 1) begin
            gen_len++;
        end else if (kind == REQ_DELETE && slot >= 1 && slot <= gen_len) begin
            gen_len--;
        end
    endtask

    // Reset, stimulus, and end of run.
    initial begin : stim_proc
        logic [BYTE_W-1:0] byte_pool[0:7];
        logic [TYPE_W-1:0] kind;
        int                mood;
        int                roll;
        int                ins_pct;
        int                del_pct;
        int                slot;
        int                value;

        for (int i = 0; i < CAP; i++) list_bytes[i] = '0;

        // Corner cases on an empty and a small list.
        add_req(REQ_LOCATE, 0, 8'h42, 1'b0);
        add_req(REQ_DELETE, 1, 8'h00, 1'b0);
        add_req(REQ_INSERT, 0, 8'h33, 1'b0);
        add_req(REQ_INSERT, 2, 8'h33, 1'b0);
        add_req(REQ_INSERT, 1, 8'h00, 1'b0);
        add_req(REQ_INSERT, 2, 8'hFF, 1'b0);
        add_req(REQ_INSERT, 1, 8'hA5, 1'b0);
        add_req(REQ_INSERT, 3, 8'h5A, 1'b0);
        add_req(REQ_LOCATE, 31, 8'hFF, 1'b0);
        add_req(REQ_UNUSED, 31, 8'hFF, 1'b0);
        add_req(REQ_DELETE, 0, 8'h00, 1'b0);
        add_req(REQ_DELETE, 5, 8'h00, 1'b0);
        add_req(REQ_DELETE, 2, 8'h00, 1'b0);

        // Fill to capacity, then exercise the full list.
        for (int i = 0; i < CAP - 3; i++) add_req(REQ_INSERT, gen_len + 1, 8'h10 + i, 1'b0);
        add_req(REQ_INSERT, 31, 8'h99, 1'b0);
        add_req(REQ_INSERT, 1, 8'h99, 1'b0);
        add_req(REQ_LOCATE, 0, 8'h77, 1'b0);
        add_req(REQ_DELETE, CAP + 1, 8'h00, 1'b0);
        add_req(REQ_DELETE, CAP, 8'h00, 1'b0);
        add_req(REQ_DELETE, 1, 8'h00, 1'b0);

        // A small pool of bytes makes locate hits and duplicates common.
        byte_pool[0] = 8'h00;
        byte_pool[1] = 8'hFF;
        for (int i = 2; i < 8; i++) byte_pool[i] = BYTE_W'($urandom_range(0, 255));

        // Random part: phases that grow, balance and shrink the list.
        for (int k = 0; k < RANDOM_REQS; k++) begin
            mood = (k / 48) % 4;
            case (mood)
                0: begin
                    ins_pct = 60;
                    del_pct = 15;
                end
                2: begin
                    ins_pct = 15;
                    del_pct = 60;
                end
                default: begin
                    ins_pct = 35;
                    del_pct = 35;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) kind = REQ_INSERT;
            else if (roll < ins_pct + del_pct) kind = REQ_DELETE;
            else if (roll < 97) kind = REQ_LOCATE;
            else kind = REQ_UNUSED;

            // Mostly legal positions; the rest anywhere in the field.
            slot = $urandom_range(0, 31);
            if ($urandom_range(0, 99) < 85) begin
                if (kind == REQ_INSERT && gen_len < CAP) slot = $urandom_range(1, gen_len + 1);
                if (kind == REQ_DELETE && gen_len > 0) slot = $urandom_range(1, gen_len);
            end
            if ($urandom_range(0, 99) < 65) value = byte_pool[$urandom_range(0, 7)];
            else value = $urandom_range(0, 255);
            add_req(kind, slot, value, k == RANDOM_REQS / 2);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is sent and every result has arrived.
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        error_count += expected_results.size();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Request driver: one word at a time, random gaps, some bursts without gaps.
    always @(posedge i_clk) begin : drive_proc
        logic nv;
        nv = s_tvalid;
        if (!i_rst_n) begin
            nv = 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(cur_req);
                reqs_accepted++;
                nv = 1'b0;
                send_gap = ((reqs_accepted / 100) % 3 == 1) ? 0 : $urandom_range(0, 8);
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_reqs[0].drain_first && expected_results.size() != 0)) begin
                    cur_req = pending_reqs.pop_front();
                    nv = 1'b1;
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= {3'b000, cur_req.item_byte, cur_req.slot};
        s_tuser  <= cur_req.req_type;
    end

    // Result monitor: checks each word and throttles the output side.
    always @(posedge i_clk) begin : monitor_proc
        logic         nr;
        t_list_result want;
        nr = m_tready;
        if (!i_rst_n) begin
            nr = 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("result %0d arrived with none expected", results_seen);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.status || m_tdata[4:0] != want.found_slot ||
                        m_tdata[9:5] != want.length || m_tdata[15:10] != '0) begin
                        error_count++;
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display({"result %0d: expected status %0d slot %0d length %0d,",
                                      " got status %0d slot %0d length %0d pad %0h"},
                                     results_seen, want.status, want.found_slot, want.length,
                                     m_tuser, m_tdata[4:0], m_tdata[9:5], m_tdata[15:10]);
                        end
                        mismatch_count++;
                    end
                end
                recv_gap = ((results_seen / 150) % 3 == 2) ? 0 : $urandom_range(0, 8);
                if (recv_gap > 0) nr = 1'b0;
                // Long hold-off so the unit backs up and stalls its input.
                if (results_seen == 300 || results_seen == 1100) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nr = 1'b0;
            end else if (!nr) begin
                if (recv_gap > 0) recv_gap--;
                else nr = 1'b1;
            end
        end
        m_tready <= nr;
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
hdl/slli_pkg.sv
hdl/slli_cell.sv
hdl/slli_locate.sv
hdl/sequential_list_insert_delete_locate_unit.sv
test/sequential_list_insert_delete_locate_unit_tb.sv
